### src/glob_wildcard_matcher_macros.svh
// Assertion macros shared by the glob matcher checker.
`ifndef GLOB_WILDCARD_MATCHER_MACROS_SVH
`define GLOB_WILDCARD_MATCHER_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low
`define GWM_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low
`define GWM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/gwm_pkg.sv
// Types and constants shared by the glob wildcard matcher modules.
`timescale 1ns / 1ps
`default_nettype none

package gwm_pkg;

  localparam int CHAR_W      = 8;
  localparam int POS_W       = 5;
  localparam int REQ_W       = 2;
  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 8;

  localparam logic [CHAR_W-1:0] STAR_CODE  = 8'd42;
  localparam logic [CHAR_W-1:0] QMARK_CODE = 8'd63;

  typedef enum logic [REQ_W-1:0] {
    REQ_WRITE = 2'd0,
    REQ_TEXT  = 2'd1,
    REQ_END   = 2'd2
  } req_type_t;

  // Per-request control broadcast to every cell
  typedef struct packed {
    logic              wr;
    logic              text;
    logic              rearm;
    logic [POS_W-1:0]  position;
    logic [CHAR_W-1:0] char_code;
  } gwm_ctrl_t;

endpackage

`default_nettype wire

### src/gwm_cell.sv
// One pattern position: stored pattern byte, active bit and star/byte match logic.
`timescale 1ns / 1ps
`default_nettype none

module gwm_cell
  import gwm_pkg::*;
#(
  parameter int IDX = 0
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire gwm_ctrl_t ctrl,
  input  wire logic      en,         // position lies below the pattern length
  input  wire logic      carry_in,   // star closure from the left neighbour
  input  wire logic      adv_in,     // advance from the left neighbour
  output logic           cur,
  output logic           carry_out,
  output logic           adv_out
);

  logic [CHAR_W-1:0] pat_r;
  logic              act_r;
  logic              act_nxt;
  logic              is_star;
  logic              hit;

  assign cur       = act_r | carry_in;
  assign is_star   = (pat_r == STAR_CODE);
  assign hit       = (pat_r == ctrl.char_code) || (pat_r == QMARK_CODE);
  assign carry_out = cur & en & is_star;
  assign adv_out   = cur & en & ~is_star & hit;

  always_comb begin
    priority if (ctrl.rearm) begin
      act_nxt = (IDX == 0);
    end else if (ctrl.text) begin
      // a star keeps its own position alive
      act_nxt = carry_out | adv_in;
    end else begin
      act_nxt = act_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r <= (IDX == 0);
    end else begin
      act_r <= act_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.wr && (32'(ctrl.position) == IDX)) begin
      pat_r <= ctrl.char_code;
    end
  end

endmodule

`default_nettype wire

### src/gwm_out_buf.sv
// Two-entry result buffer: output register plus skid stage.
`timescale 1ns / 1ps
`default_nettype none

module gwm_out_buf
  import gwm_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  wire logic push_bit,
  output logic      full,
  output logic      out_valid,
  input  wire logic out_ready,
  output logic      out_bit
);

  logic main_v_r, main_v_nxt;
  logic main_d_r, main_d_nxt;
  logic skid_v_r, skid_v_nxt;
  logic skid_d_r, skid_d_nxt;
  logic pop;

  assign pop       = main_v_r & out_ready;
  assign full      = skid_v_r;
  assign out_valid = main_v_r;
  assign out_bit   = main_d_r;

  always_comb begin
    main_v_nxt = main_v_r;
    main_d_nxt = main_d_r;
    skid_v_nxt = skid_v_r;
    skid_d_nxt = skid_d_r;
    priority if (!main_v_r) begin
      main_v_nxt = push;
      main_d_nxt = push_bit;
    end else if (pop) begin
      // advance the skid entry, else take the new request
      if (skid_v_r) begin
        main_d_nxt = skid_d_r;
        skid_v_nxt = 1'b0;
      end else begin
        main_v_nxt = push;
        main_d_nxt = push_bit;
      end
    end else if (push) begin
      skid_v_nxt = 1'b1;
      skid_d_nxt = push_bit;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_v_r <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      main_v_r <= main_v_nxt;
      skid_v_r <= skid_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    main_d_r <= main_d_nxt;
    skid_d_r <= skid_d_nxt;
  end

endmodule

`default_nettype wire

### src/glob_wildcard_matcher.sv
// Top level of the glob wildcard matcher: cell row, length register and result buffer.
// One request per cycle unless stalled; every cell updates in parallel per text byte.
// The match result is registered in the output register, or in skid if that is full.
// in_tready drops only when two results wait unread (output register and skid full).
// Reset (rst_n low, synchronous): length 0, only position zero active, buffer empty.
// Pattern bytes are not reset and must be written before use.
`timescale 1ns / 1ps
`default_nettype none

module glob_wildcard_matcher
  import gwm_pkg::*;
#(
  parameter int PATTERN_MAX = 32
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  input  wire logic [IN_TDATA_W-1:0]  in_tdata,   // [4:0] position, [12:5] char_code
  input  wire logic [REQ_W-1:0]       in_tuser,   // [1:0] req_type
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  output logic [OUT_TDATA_W-1:0]      out_tdata,  // [0] matched
  input  wire logic                   cfg_wr_en,
  input  wire logic [5:0]             cfg_wr_data // pattern_length
);

  localparam int LENW = $clog2(PATTERN_MAX + 1);
  localparam int CW   = (LENW > 6) ? LENW : 6;

  logic [LENW-1:0]        len_r, len_nxt;
  logic [PATTERN_MAX-1:0] en_r, en_nxt;
  logic                   tail_r, tail_nxt;
  logic [CW-1:0]          cfg_ext;
  logic [CW-1:0]          cfg_clamp;
  logic                   accept;
  req_type_t              req;
  gwm_ctrl_t              ctrl;
  logic [PATTERN_MAX:0]   cur_vec;
  logic [PATTERN_MAX:0]   carry;
  logic [PATTERN_MAX:0]   adv;
  logic                   match;
  logic                   buf_full;
  logic                   buf_bit;

  assign accept = in_tvalid & in_tready;
  assign req    = req_type_t'(in_tuser);

  always_comb begin
    ctrl           = '0;
    ctrl.position  = in_tdata[POS_W-1:0];
    ctrl.char_code = in_tdata[POS_W +: CHAR_W];
    unique case (req)
      REQ_WRITE: ctrl.wr    = accept;
      REQ_TEXT:  ctrl.text  = accept;
      REQ_END:   ctrl.rearm = accept;
      default:   ctrl.wr    = 1'b0;
    endcase
  end

  // Length above the store depth is used as the full depth
  assign cfg_ext   = CW'(cfg_wr_data);
  assign cfg_clamp = (cfg_ext > CW'(PATTERN_MAX)) ? CW'(PATTERN_MAX) : cfg_ext;

  always_comb begin
    len_nxt = len_r;
    en_nxt  = en_r;
    if (cfg_wr_en) begin
      len_nxt = LENW'(cfg_clamp);
      for (int i = 0; i < PATTERN_MAX; i++) begin
        en_nxt[i] = (CW'(i) < cfg_clamp);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r  <= '0;
      en_r   <= '0;
      tail_r <= 1'b0;
    end else begin
      len_r  <= len_nxt;
      en_r   <= en_nxt;
      tail_r <= tail_nxt;
    end
  end

  assign carry[0] = 1'b0;
  assign adv[0]   = 1'b0;

  for (genvar g = 0; g < PATTERN_MAX; g++) begin : g_cell
    gwm_cell #(
      .IDX (g)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctrl      (ctrl),
      .en        (en_r[g]),
      .carry_in  (carry[g]),
      .adv_in    (adv[g]),
      .cur       (cur_vec[g]),
      .carry_out (carry[g+1]),
      .adv_out   (adv[g+1])
    );
  end

  // Position past the last pattern byte: reached only by advance or closure
  assign cur_vec[PATTERN_MAX] = tail_r | carry[PATTERN_MAX];

  always_comb begin
    priority if (ctrl.rearm) begin
      tail_nxt = 1'b0;
    end else if (ctrl.text) begin
      tail_nxt = adv[PATTERN_MAX];
    end else begin
      tail_nxt = tail_r;
    end
  end

  assign match = cur_vec[len_r];

  gwm_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (ctrl.rearm),
    .push_bit  (match),
    .full      (buf_full),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_bit   (buf_bit)
  );

  assign in_tready = ~buf_full;
  assign out_tdata = {{(OUT_TDATA_W-1){1'b0}}, buf_bit};

endmodule

`default_nettype wire

### src/gwm_checker.sv
// Port-level assertion checker for the glob wildcard matcher, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

`include "glob_wildcard_matcher_macros.svh"

module gwm_checker
  import gwm_pkg::*;
(
  input wire logic                   clk,
  input wire logic                   rst_n,
  input wire logic                   in_tvalid,
  input wire logic                   in_tready,
  input wire logic [REQ_W-1:0]       in_tuser,
  input wire logic                   out_tvalid,
  input wire logic                   out_tready,
  input wire logic [OUT_TDATA_W-1:0] out_tdata
);

  // Hold a stalled result
  `GWM_ASSERT_NEXT(a_out_hold,
    out_tvalid && !out_tready,
    out_tvalid && $stable(out_tdata),
    "stalled result dropped or changed")

  // Upper result bits are padding
  `GWM_ASSERT_IMPL(a_out_pad,
    out_tvalid,
    out_tdata[OUT_TDATA_W-1:1] == '0,
    "result padding not zero")

  // An end request into an empty output gives a result next cycle
  `GWM_ASSERT_NEXT(a_end_result,
    in_tvalid && in_tready && (in_tuser == REQ_END) && !out_tvalid,
    out_tvalid,
    "end request gave no result")

  // Back-pressure on input only while a result waits
  `GWM_ASSERT_IMPL(a_stall_cause,
    !in_tready,
    out_tvalid,
    "input stalled with no pending result")

endmodule

bind glob_wildcard_matcher gwm_checker u_gwm_checker (.*);

`default_nettype wire

### bench/testbench.sv
// Self-checking bench for the glob wildcard matcher: pattern loads, text streams, match checks.
`timescale 1ns / 1ps

import gwm_pkg::*;

class match_scoreboard;
  logic [CHAR_W-1:0] pattern [32];
  bit [32:0]         active;
  int unsigned       length_reg;
  bit                expected_matches [$];
  int unsigned       errors;

  function new();
    active     = 33'd1;
    length_reg = 0;
    errors     = 0;
  endfunction

  function int unsigned used_length();
    return (length_reg > 32) ? 32 : length_reg;
  endfunction

  function void set_length(logic [5:0] value);
    length_reg = 32'(value);
  endfunction

  function int unsigned pending();
    return expected_matches.size();
  endfunction

  // Positions after star closure, limited to the length in use
  function bit [32:0] star_closed(int unsigned len);
    bit [32:0] s;
    s = active;
    for (int i = 0; i < len; i++)
      if (s[i] && pattern[i] == STAR_CODE) s[i+1] = 1'b1;
    return s;
  endfunction

  function void note_request(logic [REQ_W-1:0] req, logic [POS_W-1:0] pos,
                             logic [CHAR_W-1:0] ch);
    int unsigned len;
    bit [32:0]   cur;
    bit [32:0]   nxt;
    len = used_length();
    case (req)
      REQ_WRITE: begin
        pattern[pos] = ch;
      end
      REQ_TEXT: begin
        cur = star_closed(len);
        nxt = '0;
        for (int i = 0; i < len; i++) begin
          if (!cur[i]) continue;
          if (pattern[i] == STAR_CODE) nxt[i] = 1'b1;
          else if (pattern[i] == ch || pattern[i] == QMARK_CODE) nxt[i+1] = 1'b1;
        end
        active = nxt;
      end
      REQ_END: begin
        cur = star_closed(len);
        expected_matches = {expected_matches, cur[len]};
        active = 33'd1;
      end
      default: ;
    endcase
  endfunction

  function void check_match(bit got);
    bit want;
    if (expected_matches.size() == 0) begin
      $display("%0t: unexpected result, expected none, actual matched=%0b", $time, got);
      errors++;
    end else begin
      want = expected_matches.pop_front();
      if (want !== got) begin
        $display("%0t: matched mismatch, expected %0b, actual %0b", $time, want, got);
        errors++;
      end
    end
  endfunction
endclass

module testbench;

  localparam int          PATTERN_MAX   = 32;
  localparam logic [1:0]  REQ_UNUSED    = 2'd3;
  localparam int unsigned HOLD_CYCLES   = 300;
  localparam int unsigned STALL_LIMIT   = 2000;
  localparam int unsigned SETTLE_CYCLES = 4;
  localparam int unsigned TAIL_CYCLES   = 10;

  logic                   clk;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;
  logic [REQ_W-1:0]       in_tuser;
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   cfg_wr_en;
  logic [5:0]             cfg_wr_data;

  match_scoreboard ledger = new();
  int unsigned     requests_sent = 0;
  bit              steady = 1'b0;
  bit              hold_wanted = 1'b0;
  bit              hold_done = 1'b0;

  glob_wildcard_matcher #(.PATTERN_MAX(PATTERN_MAX)) uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [CHAR_W-1:0] any_char();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 65) return 8'h61 + 8'($urandom_range(2));
    if (r < 72) return 8'h00;
    if (r < 79) return 8'hFF;
    return 8'($urandom_range(255));
  endfunction

  function automatic logic [CHAR_W-1:0] pattern_char();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 25) return STAR_CODE;
    if (r < 45) return QMARK_CODE;
    return any_char();
  endfunction

  // Offer one request, hold it until taken, then note it for prediction
  task automatic send_req(input logic [REQ_W-1:0] req, input logic [POS_W-1:0] pos,
                          input logic [CHAR_W-1:0] ch);
    while (!steady && $urandom_range(99) < 13) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= req;
    in_tdata  <= {3'b000, ch, pos};
    do @(posedge clk); while (!in_tready);
    ledger.note_request(req, pos, ch);
    if (req != REQ_UNUSED) requests_sent++;
    steady = (requests_sent >= 550 && requests_sent < 720);
    @(negedge clk);
  endtask

  task automatic program_length(input logic [5:0] value);
    in_tvalid <= 1'b0;
    while (ledger.pending() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    ledger.set_length(value);
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic load_pattern(input int unsigned n);
    for (int i = 0; i < n; i++) send_req(REQ_WRITE, 5'(i), pattern_char());
  endtask

  // Build text that mostly fits the stored pattern, then spoil it now and then
  task automatic send_string();
    int unsigned       len;
    int unsigned       k;
    logic [CHAR_W-1:0] txt [$];
    len = ledger.used_length();
    for (int i = 0; i < len; i++) begin
      if (ledger.pattern[i] == STAR_CODE) repeat ($urandom_range(3)) txt = {txt, any_char()};
      else if (ledger.pattern[i] == QMARK_CODE) txt = {txt, any_char()};
      else txt = {txt, ledger.pattern[i]};
    end
    k = $urandom_range(99);
    if (k < 15 && txt.size() != 0) txt[$urandom_range(txt.size() - 1)] = any_char();
    else if (k < 22) txt = {txt, any_char()};
    else if (k < 29 && txt.size() != 0) txt.delete($urandom_range(txt.size() - 1));
    foreach (txt[j]) begin
      k = $urandom_range(99);
      if (k < 3) send_req(REQ_UNUSED, 5'($urandom), 8'($urandom));
      else if (k < 6) send_req(REQ_WRITE, 5'($urandom), pattern_char());
      send_req(REQ_TEXT, 5'($urandom), txt[j]);
    end
    // leave the odd string unterminated so it runs into the next one
    if ($urandom_range(9) != 0) send_req(REQ_END, 5'($urandom), 8'($urandom));
  endtask

  // Receiver: random back-pressure, one long hold-off on request
  initial begin
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_wanted && !hold_done) begin
        out_tready <= 1'b0;
        hold_done = 1'b1;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
      end else begin
        out_tready <= steady || ($urandom_range(99) >= 13);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) ledger.check_match(out_tdata[0]);
  end

  initial begin
    int unsigned quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet = 0;
      else quiet++;
    end
    $display("%0t: no request or result moved for %0d cycles", $time, STALL_LIMIT);
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    int unsigned phase;
    int unsigned r;
    logic [5:0]  plen;
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    in_tuser    = '0;
    cfg_wr_en   = 1'b0;
    cfg_wr_data = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Empty pattern: empty text matches, any byte spoils it
    send_req(REQ_END, 5'd0, 8'd0);
    send_req(REQ_TEXT, 5'd31, 8'h00);
    send_req(REQ_END, 5'd0, 8'd0);
    send_req(REQ_UNUSED, 5'd31, 8'hFF);

    program_length(6'd4);
    send_req(REQ_WRITE, 5'd0, STAR_CODE);
    send_req(REQ_WRITE, 5'd1, QMARK_CODE);
    send_req(REQ_WRITE, 5'd2, 8'hFF);
    send_req(REQ_WRITE, 5'd3, STAR_CODE);
    send_req(REQ_END, 5'd0, 8'd0);
    send_req(REQ_TEXT, 5'd0, 8'h00);
    send_req(REQ_TEXT, 5'd0, 8'hFF);
    send_req(REQ_END, 5'd0, 8'd0);
    send_req(REQ_TEXT, 5'd0, 8'hFF);
    send_req(REQ_END, 5'd0, 8'd0);
    // zero byte in the pattern, written mid-string
    send_req(REQ_TEXT, 5'd0, 8'h05);
    send_req(REQ_WRITE, 5'd2, 8'h00);
    send_req(REQ_TEXT, 5'd0, 8'h00);
    send_req(REQ_END, 5'd0, 8'd0);
    send_req(REQ_WRITE, 5'd31, 8'hFF);

    // Pattern of stars only against empty text
    program_length(6'd1);
    send_req(REQ_END, 5'd0, 8'd0);

    phase = 0;
    while (requests_sent < 1000) begin
      r = $urandom_range(99);
      if (phase == 0) plen = 6'd63;
      else if (phase == 1) plen = 6'd32;
      else if (r < 8) plen = 6'd0;
      else if (r < 70) plen = 6'($urandom_range(1, 6));
      else if (r < 80) plen = 6'($urandom_range(7, 16));
      else if (r < 90) plen = 6'd32;
      else plen = 6'($urandom_range(33, 63));
      program_length(plen);
      load_pattern((plen > 32) ? 32 : plen);
      // Starve the output and keep pushing short strings so the input stalls
      if (!hold_wanted && requests_sent >= 300) begin
        hold_wanted = 1'b1;
        repeat (10) begin
          send_req(REQ_TEXT, 5'($urandom), any_char());
          send_req(REQ_END, 5'($urandom), 8'($urandom));
        end
      end
      repeat ($urandom_range(3, 8)) send_string();
      phase++;
    end

    in_tvalid <= 1'b0;
    while (ledger.pending() != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);
    if (ledger.pending() != 0) begin
      $display("%0t: %0d results never arrived", $time, ledger.pending());
      ledger.errors++;
    end
    if (ledger.errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
